### hdl/ordered_sequence_store_macros.svh
// Assertion helpers for the ordered sequence store checker.
// Both sample on clk and are disabled while rst_n is low.
`ifndef ORDERED_SEQUENCE_STORE_MACROS_SVH
`define ORDERED_SEQUENCE_STORE_MACROS_SVH

// Same-cycle implication.
`define OSS_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ordered_sequence_store port check failed");

// Next-cycle implication.
`define OSS_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ordered_sequence_store port check failed");

`endif

### hdl/oss_pkg.sv
package oss_pkg;

    localparam int DEF_CAPACITY = 16;
    localparam int KEY_W        = 32;

    // command kinds
    localparam logic [3:0] K_SORT      = 4'd0;
    localparam logic [3:0] K_BACK      = 4'd1;
    localparam logic [3:0] K_FRONT     = 4'd2;
    localparam logic [3:0] K_DEL_KEY   = 4'd3;
    localparam logic [3:0] K_DEL_BACK  = 4'd4;
    localparam logic [3:0] K_DEL_FRONT = 4'd5;
    localparam logic [3:0] K_REVERSE   = 4'd6;
    localparam logic [3:0] K_CLEAR     = 4'd7;
    localparam logic [3:0] K_READ      = 4'd8;

    // result status
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_EMPTY   = 2'd1;
    localparam logic [1:0] ST_MISSING = 2'd2;
    localparam logic [1:0] ST_FULL    = 2'd3;

    typedef struct packed {
        logic lt;
        logic eq;
    } cmp_t;

endpackage

### hdl/oss_key_cmp.sv
// Shared signed key comparator.
module oss_key_cmp (
    input  logic signed [oss_pkg::KEY_W-1:0] a,
    input  logic signed [oss_pkg::KEY_W-1:0] b,
    output oss_pkg::cmp_t                    res
);
    import oss_pkg::*;

    always_comb
    begin
        res.lt = (a < b);
        res.eq = (a == b);
    end

endmodule

### hdl/ordered_sequence_store.sv
// One transaction in flight: cmd_stall is high from the accept until the result is staged,
// and staging waits while res_stall holds the previous result in the output register.
// Sorted insert, insert front, delete key and delete front make one pass over the keys;
// reverse of two or more keys swaps pairs from both ends; read waits on the registered
// memory read; everything else goes straight to the result stage.
// Reset (rst_n low, async): count cleared, no result pending; key memory not cleared.
module ordered_sequence_store #(
    parameter int CAPACITY = oss_pkg::DEF_CAPACITY
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // command channel
    input  logic                             cmd_valid,
    output logic                             cmd_stall,
    input  logic [3:0]                       kind,
    input  logic signed [oss_pkg::KEY_W-1:0] item_key,
    input  logic [3:0]                       position,
    // result channel
    output logic                             res_valid,
    input  logic                             res_stall,
    output logic [1:0]                       status,
    output logic signed [oss_pkg::KEY_W-1:0] read_key,
    output logic [4:0]                       entry_count
);
    import oss_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;   // memory index
    localparam int CW = $clog2(CAPACITY + 1);                     // count, 0..CAPACITY

    // sequencer states
    localparam logic [2:0] S_IDLE       = 3'd0;
    localparam logic [2:0] S_WALK       = 3'd1;  // insert / delete pass, front to back
    localparam logic [2:0] S_RD_WAIT    = 3'd2;
    localparam logic [2:0] S_RV_LO      = 3'd3;
    localparam logic [2:0] S_RV_HI      = 3'd4;
    localparam logic [2:0] S_RV_SWAP_LO = 3'd5;
    localparam logic [2:0] S_RV_SWAP_HI = 3'd6;
    localparam logic [2:0] S_DONE       = 3'd7;

    logic [2:0]          state_reg, state_next;
    logic [CW-1:0]       count_reg, count_next;

    // walk control
    logic                del_reg, del_next;      // walk deletes instead of inserting
    logic                force_reg, force_next;  // hit forced at index zero (front ops)
    logic                found_reg, found_next;
    logic [CW-1:0]       ridx_reg, ridx_next;    // next index to read
    logic                vld_reg, vld_next;      // read data arriving this cycle
    logic [AW-1:0]       didx_reg, didx_next;    // index of arriving data

    // payload
    logic [KEY_W-1:0]    key_reg, key_next;
    logic [KEY_W-1:0]    carry_reg, carry_next;  // key pushed one slot back
    logic [KEY_W-1:0]    tmp_reg, tmp_next;      // low key held during a swap
    logic [AW-1:0]       lo_reg, lo_next;
    logic [AW-1:0]       hi_reg, hi_next;
    logic [1:0]          res_status_reg, res_status_next;
    logic [KEY_W-1:0]    res_key_reg, res_key_next;

    // result stage
    logic                res_valid_reg, res_valid_next;
    logic [1:0]          status_reg, status_next;
    logic [KEY_W-1:0]    read_key_reg, read_key_next;
    logic [4:0]          entry_count_reg, entry_count_next;

    // key memory, 1 write + 1 registered read per cycle
    logic [KEY_W-1:0]    mem_array [CAPACITY];
    logic                mem_we;
    logic [AW-1:0]       mem_waddr;
    logic [KEY_W-1:0]    mem_wdata;
    logic                mem_re;
    logic [AW-1:0]       mem_raddr;
    logic [KEY_W-1:0]    rdata_reg;

    cmp_t                cmp;
    logic                full;
    logic                empty;
    logic                hit;
    logic                rv_more;
    logic [CW-1:0]       count_m1;
    logic [AW:0]         lo_p2;

    oss_key_cmp u_cmp (
        .a   (rdata_reg),
        .b   (key_reg),
        .res (cmp)
    );

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem_array[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= mem_array[mem_raddr];
        end
    end

    assign full     = (count_reg == CW'(CAPACITY));
    assign empty    = (count_reg == '0);
    assign count_m1 = count_reg - 1'b1;
    assign lo_p2    = {1'b0, lo_reg} + (AW+1)'(2);
    assign rv_more  = (lo_p2 < {1'b0, hi_reg});   // another pair left after this one

    // Insert hits at the first key >= new key; delete at the first equal key; front ops at index zero.
    always_comb
    begin
        if (force_reg)
        begin
            hit = (didx_reg == '0);
        end
        else if (del_reg)
        begin
            hit = cmp.eq;
        end
        else
        begin
            hit = !cmp.lt;
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        count_next       = count_reg;
        del_next         = del_reg;
        force_next       = force_reg;
        found_next       = found_reg;
        ridx_next        = ridx_reg;
        vld_next         = 1'b0;
        didx_next        = didx_reg;
        key_next         = key_reg;
        carry_next       = carry_reg;
        tmp_next         = tmp_reg;
        lo_next          = lo_reg;
        hi_next          = hi_reg;
        res_status_next  = res_status_reg;
        res_key_next     = res_key_reg;
        res_valid_next   = res_valid_reg;
        status_next      = status_reg;
        read_key_next    = read_key_reg;
        entry_count_next = entry_count_reg;
        mem_we           = 1'b0;
        mem_waddr        = '0;
        mem_wdata        = '0;
        mem_re           = 1'b0;
        mem_raddr        = '0;

        // result taken downstream
        if (res_valid_reg && !res_stall)
        begin
            res_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    key_next        = item_key;
                    res_status_next = ST_OK;
                    res_key_next    = '0;
                    found_next      = 1'b0;
                    ridx_next       = '0;
                    state_next      = S_DONE;
                    unique case (kind) inside
                        K_SORT, K_FRONT:
                        begin
                            if (full)
                            begin
                                res_status_next = ST_FULL;
                            end
                            else
                            begin
                                del_next   = 1'b0;
                                force_next = (kind == K_FRONT);
                                state_next = S_WALK;
                            end
                        end
                        K_BACK:
                        begin
                            if (full)
                            begin
                                res_status_next = ST_FULL;
                            end
                            else
                            begin
                                mem_we     = 1'b1;
                                mem_waddr  = count_reg[AW-1:0];
                                mem_wdata  = item_key;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        K_DEL_KEY, K_DEL_FRONT:
                        begin
                            if (empty)
                            begin
                                res_status_next = ST_EMPTY;
                            end
                            else
                            begin
                                del_next   = 1'b1;
                                force_next = (kind == K_DEL_FRONT);
                                state_next = S_WALK;
                            end
                        end
                        K_DEL_BACK:
                        begin
                            if (empty)
                            begin
                                res_status_next = ST_EMPTY;
                            end
                            else
                            begin
                                count_next = count_m1;
                            end
                        end
                        K_REVERSE:
                        begin
                            if (empty)
                            begin
                                res_status_next = ST_EMPTY;
                            end
                            else if (count_reg != CW'(1))
                            begin
                                lo_next    = '0;
                                hi_next    = count_m1[AW-1:0];
                                state_next = S_RV_LO;
                            end
                        end
                        K_CLEAR:
                        begin
                            count_next = '0;
                        end
                        K_READ:
                        begin
                            if (empty)
                            begin
                                res_status_next = ST_EMPTY;
                            end
                            else if (32'(position) >= 32'(count_reg))
                            begin
                                res_status_next = ST_MISSING;
                            end
                            else
                            begin
                                mem_re     = 1'b1;
                                mem_raddr  = AW'(position);
                                state_next = S_RD_WAIT;
                            end
                        end
                        default:
                        begin
                            // undefined kind: no operation, status ok
                        end
                    endcase
                end
            end

            S_WALK:
            begin
                // issue the next read, one entry per cycle
                if (ridx_reg < count_reg)
                begin
                    mem_re    = 1'b1;
                    mem_raddr = ridx_reg[AW-1:0];
                    ridx_next = ridx_reg + 1'b1;
                    vld_next  = 1'b1;
                    didx_next = ridx_reg[AW-1:0];
                end

                if (vld_reg)
                begin
                    if (!del_reg)
                    begin
                        // insert: drop key at the hit, then ripple keys one slot back
                        if (found_reg)
                        begin
                            mem_we     = 1'b1;
                            mem_waddr  = didx_reg;
                            mem_wdata  = carry_reg;
                            carry_next = rdata_reg;
                        end
                        else if (hit)
                        begin
                            mem_we     = 1'b1;
                            mem_waddr  = didx_reg;
                            mem_wdata  = key_reg;
                            carry_next = rdata_reg;
                            found_next = 1'b1;
                        end
                    end
                    else
                    begin
                        // delete: after the hit, move each key one slot forward
                        if (found_reg)
                        begin
                            mem_we    = 1'b1;
                            mem_waddr = didx_reg - 1'b1;
                            mem_wdata = rdata_reg;
                        end
                        else if (hit)
                        begin
                            found_next = 1'b1;
                        end
                    end
                end
                else if (ridx_reg >= count_reg)
                begin
                    // pass finished: close out
                    if (!del_reg)
                    begin
                        mem_we     = 1'b1;
                        mem_waddr  = count_reg[AW-1:0];
                        mem_wdata  = found_reg ? carry_reg : key_reg;
                        count_next = count_reg + 1'b1;
                    end
                    else if (found_reg)
                    begin
                        count_next = count_m1;
                    end
                    else
                    begin
                        res_status_next = ST_MISSING;
                    end
                    state_next = S_DONE;
                end
            end

            S_RD_WAIT:
            begin
                res_key_next = rdata_reg;
                state_next   = S_DONE;
            end

            S_RV_LO:
            begin
                mem_re     = 1'b1;
                mem_raddr  = lo_reg;
                state_next = S_RV_HI;
            end

            S_RV_HI:
            begin
                mem_re     = 1'b1;
                mem_raddr  = hi_reg;
                tmp_next   = rdata_reg;
                state_next = S_RV_SWAP_LO;
            end

            S_RV_SWAP_LO:
            begin
                mem_we    = 1'b1;
                mem_waddr = lo_reg;
                mem_wdata = rdata_reg;
                if (rv_more)
                begin
                    mem_re    = 1'b1;
                    mem_raddr = lo_reg + 1'b1;
                end
                state_next = S_RV_SWAP_HI;
            end

            S_RV_SWAP_HI:
            begin
                mem_we    = 1'b1;
                mem_waddr = hi_reg;
                mem_wdata = tmp_reg;
                if (rv_more)
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = hi_reg - 1'b1;
                    tmp_next   = rdata_reg;
                    lo_next    = lo_reg + 1'b1;
                    hi_next    = hi_reg - 1'b1;
                    state_next = S_RV_SWAP_LO;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end

            S_DONE:
            begin
                // stage the result once the output register is free
                if (!res_valid_reg || !res_stall)
                begin
                    res_valid_next   = 1'b1;
                    status_next      = res_status_reg;
                    read_key_next    = res_key_reg;
                    entry_count_next = 5'(count_reg);
                    state_next       = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            del_reg       <= 1'b0;
            force_reg     <= 1'b0;
            found_reg     <= 1'b0;
            ridx_reg      <= '0;
            vld_reg       <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            del_reg       <= del_next;
            force_reg     <= force_next;
            found_reg     <= found_next;
            ridx_reg      <= ridx_next;
            vld_reg       <= vld_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        didx_reg        <= didx_next;
        key_reg         <= key_next;
        carry_reg       <= carry_next;
        tmp_reg         <= tmp_next;
        lo_reg          <= lo_next;
        hi_reg          <= hi_next;
        res_status_reg  <= res_status_next;
        res_key_reg     <= res_key_next;
        status_reg      <= status_next;
        read_key_reg    <= read_key_next;
        entry_count_reg <= entry_count_next;
    end

    assign cmd_stall   = (state_reg != S_IDLE);
    assign res_valid   = res_valid_reg;
    assign status      = status_reg;
    assign read_key    = read_key_reg;
    assign entry_count = entry_count_reg;

endmodule

### hdl/oss_checker.sv
`include "ordered_sequence_store_macros.svh"

module oss_checker #(
    parameter int CAPACITY = oss_pkg::DEF_CAPACITY
) (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             cmd_valid,
    input logic                             cmd_stall,
    input logic                             res_valid,
    input logic                             res_stall,
    input logic [1:0]                       status,
    input logic signed [oss_pkg::KEY_W-1:0] read_key,
    input logic [4:0]                       entry_count
);
    import oss_pkg::*;

    localparam logic [4:0] CAP_LO = 5'(CAPACITY);

    logic [KEY_W+6:0] res_word;

    assign res_word = {status, read_key, entry_count};

    // one command in flight: an accepted transaction closes the command side
    `OSS_ASSERT_NXT(a_one_cmd, cmd_valid && !cmd_stall, cmd_stall)
    // stalled result holds
    `OSS_ASSERT_NXT(a_res_hold, res_valid && res_stall, res_valid && $stable(res_word))
    // only a good read carries a key
    `OSS_ASSERT_IMP(a_key_zero, res_valid && status != ST_OK, read_key == '0)
    `OSS_ASSERT_IMP(a_empty_cnt, res_valid && status == ST_EMPTY, entry_count == '0)
    `OSS_ASSERT_IMP(a_full_cnt, res_valid && status == ST_FULL, entry_count == CAP_LO)

endmodule

bind ordered_sequence_store oss_checker #(.CAPACITY(CAPACITY)) u_oss_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd_valid   (cmd_valid),
    .cmd_stall   (cmd_stall),
    .res_valid   (res_valid),
    .res_stall   (res_stall),
    .status      (status),
    .read_key    (read_key),
    .entry_count (entry_count)
);
